[rtl/ipcp_pkg.sv]
// Shared widths, register indexes and constants of the inverse Park/Clarke PWM block.
package ipcp_pkg;

    // Defaults for the top-level parameters.
    localparam int PWM_PERIOD_DEF = 4500;
    localparam int ANGLE_BITS_DEF = 12;

    // Field and register widths.
    localparam int QV_W   = 16;
    localparam int ANG_W  = 12;
    localparam int DUTY_W = 13;
    localparam int REG_W  = 16;

    // Stream bus widths.
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 40;
    localparam int OUT_TUSER_W = 1;

    // Register reset values in millivolts.
    localparam logic [REG_W-1:0] SUPPLY_RST = 16'd12000;
    localparam logic [REG_W-1:0] LIMIT_RST  = 16'd12600;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        REG_SUPPLY = 1'b0,
        REG_LIMIT  = 1'b1
    } t_reg_idx;

    // CORDIC sine/cosine generator.
    localparam int CORDIC_STEPS = 24;
    localparam int XY_W = 34;
    localparam int Z_W  = 32;
    localparam logic signed [XY_W-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;

    // sqrt(3)/2 in Q1.15.
    localparam logic signed [15:0] SQRT3_HALF_Q15 = 16'sd28378;

    // Arctangent of 2^-idx, with a full turn equal to 2^32.
    function automatic logic signed [Z_W-1:0] atan_turn32(input int idx);
        logic signed [Z_W-1:0] res;
        unique case (idx)
            0:       res = 32'sd536870912;
            1:       res = 32'sd316933406;
            2:       res = 32'sd167458907;
            3:       res = 32'sd85004756;
            4:       res = 32'sd42667331;
            5:       res = 32'sd21354465;
            6:       res = 32'sd10679838;
            7:       res = 32'sd5340245;
            8:       res = 32'sd2670163;
            9:       res = 32'sd1335087;
            10:      res = 32'sd667544;
            11:      res = 32'sd333772;
            12:      res = 32'sd166886;
            13:      res = 32'sd83443;
            14:      res = 32'sd41722;
            15:      res = 32'sd20861;
            16:      res = 32'sd10430;
            17:      res = 32'sd5215;
            18:      res = 32'sd2608;
            19:      res = 32'sd1304;
            20:      res = 32'sd652;
            21:      res = 32'sd326;
            22:      res = 32'sd163;
            23:      res = 32'sd81;
            default: res = '0;
        endcase
        return res;
    endfunction

endpackage

[rtl/inverse_park_clarke_pwm_duty_top.sv]
// Inverse Park/Clarke transform from q-axis voltage and angle to three PWM compare counts.
//
// One beat enters per clock and one result beat leaves per clock while the output is not
// stalled. The stages include the 24-stage CORDIC sine/cosine pipeline and the divider,
// which resolves one quotient bit per stage. All stages share one advance enable, so a
// stalled output register holds the whole pipeline and no beat is lost or repeated.
// The supply and limit registers feed the pipeline directly and are to be written by the
// user only while idle; the block itself does not enforce this.
module inverse_park_clarke_pwm_duty_top #(
    parameter int PWM_PERIOD = ipcp_pkg::PWM_PERIOD_DEF,
    parameter int ANGLE_BITS = ipcp_pkg::ANGLE_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration write port.
    input  logic                                i_cfg_we,
    input  ipcp_pkg::t_reg_idx                  i_cfg_idx,
    input  logic [ipcp_pkg::REG_W-1:0]          i_cfg_wdata,
    // Input stream.
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // [15:0] quad_voltage, [27:16] elec_angle, [31:28] zero
    input  logic [ipcp_pkg::IN_TDATA_W-1:0]     i_s_tdata,
    // Output stream.
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // [12:0] duty_a, [25:13] duty_b, [38:26] duty_c, [39] zero
    output logic [ipcp_pkg::OUT_TDATA_W-1:0]    o_m_tdata,
    // [0] supply_zero
    output logic [ipcp_pkg::OUT_TUSER_W-1:0]    o_m_tuser
);
    import ipcp_pkg::*;

    localparam int PW   = $clog2(PWM_PERIOD + 1);
    localparam int NW   = REG_W + PW;
    localparam int UC_W = REG_W + 30;
    localparam int UW   = UC_W + 3;
    localparam int SPL  = UC_W / 2;
    localparam int FW   = UC_W + PW;
    localparam int SH   = 32 - ANGLE_BITS;
    localparam int NSTG = CORDIC_STEPS + 8 + PW;
    localparam logic [ANG_W-1:0] ANG_MASK = ANG_W'((64'd1 << ANGLE_BITS) - 64'd1);
    localparam logic [PW-1:0] PERIOD = PW'(PWM_PERIOD);
    localparam logic signed [XY_W-1:0] Q15_HALF = 16384;
    localparam logic signed [XY_W-1:0] Q15_MAX  = 32767;

    // Round a Q30 CORDIC output to Q15 and clamp it to +-32767.
    function automatic logic signed [15:0] to_q15(input logic signed [XY_W-1:0] v);
        logic signed [XY_W-1:0] r;
        logic signed [15:0]     res;
        r = (v + Q15_HALF) >>> 15;
        if (r > Q15_MAX) begin
            res = 16'sd32767;
        end else if (r < -Q15_MAX) begin
            res = -16'sd32767;
        end else begin
            res = r[15:0];
        end
        return res;
    endfunction

    // Configuration registers.
    logic [REG_W-1:0] r_supply;
    logic [REG_W-1:0] r_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_supply <= SUPPLY_RST;
            r_limit  <= LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_SUPPLY: r_supply <= i_cfg_wdata;
                REG_LIMIT:  r_limit  <= i_cfg_wdata;
            endcase
        end
    end

    // Valid bits travel with the data; every stage advances on one shared enable.
    logic [NSTG-1:0] r_v;
    logic            adv;

    assign adv        = !r_v[NSTG-1] || i_m_tready;
    assign o_s_tready = adv;
    assign o_m_tvalid = r_v[NSTG-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (adv) begin
            r_v <= {r_v[NSTG-2:0], i_s_tvalid};
        end
    end

    // Input unpacking and angle to 32-bit phase.
    logic signed [QV_W-1:0] in_uq;
    logic [ANG_W-1:0]       in_ang;
    logic [31:0]            in_phase;

    assign in_uq    = i_s_tdata[QV_W-1:0];
    assign in_ang   = i_s_tdata[QV_W +: ANG_W];
    assign in_phase = 32'(in_ang & ANG_MASK) << SH;

    // CORDIC rotation stages over the first quadrant.
    logic signed [XY_W-1:0] r_x    [0:CORDIC_STEPS];
    logic signed [XY_W-1:0] r_y    [0:CORDIC_STEPS];
    logic signed [Z_W-1:0]  r_z    [0:CORDIC_STEPS];
    logic [1:0]             r_quad [0:CORDIC_STEPS];
    logic signed [QV_W-1:0] r_uq   [0:CORDIC_STEPS];
    logic signed [XY_W-1:0] n_x    [0:CORDIC_STEPS-1];
    logic signed [XY_W-1:0] n_y    [0:CORDIC_STEPS-1];
    logic signed [Z_W-1:0]  n_z    [0:CORDIC_STEPS-1];

    always_comb begin
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            if (!r_z[i][Z_W-1]) begin
                n_x[i] = r_x[i] - (r_y[i] >>> i);
                n_y[i] = r_y[i] + (r_x[i] >>> i);
                n_z[i] = r_z[i] - atan_turn32(i);
            end else begin
                n_x[i] = r_x[i] + (r_y[i] >>> i);
                n_y[i] = r_y[i] - (r_x[i] >>> i);
                n_z[i] = r_z[i] + atan_turn32(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_x[0]    <= CORDIC_GAIN_Q30;
            r_y[0]    <= '0;
            r_z[0]    <= signed'({2'b00, in_phase[29:0]});
            r_quad[0] <= in_phase[31:30];
            r_uq[0]   <= in_uq;
            for (int i = 0; i < CORDIC_STEPS; i++) begin
                r_x[i+1]    <= n_x[i];
                r_y[i+1]    <= n_y[i];
                r_z[i+1]    <= n_z[i];
                r_quad[i+1] <= r_quad[i];
                r_uq[i+1]   <= r_uq[i];
            end
        end
    end

    // Round to Q15 and unfold the quadrant by symmetry.
    logic signed [15:0]     q_s;
    logic signed [15:0]     q_c;
    logic signed [15:0]     n_sn;
    logic signed [15:0]     n_cs;
    logic signed [15:0]     r_sn;
    logic signed [15:0]     r_cs;
    logic signed [QV_W-1:0] r_uq_rnd;

    always_comb begin
        q_s = to_q15(r_y[CORDIC_STEPS]);
        q_c = to_q15(r_x[CORDIC_STEPS]);
        unique case (r_quad[CORDIC_STEPS])
            2'd0: begin
                n_sn = q_s;
                n_cs = q_c;
            end
            2'd1: begin
                n_sn = q_c;
                n_cs = -q_s;
            end
            2'd2: begin
                n_sn = -q_s;
                n_cs = -q_c;
            end
            2'd3: begin
                n_sn = -q_c;
                n_cs = q_s;
            end
        endcase
    end

    // Rotation products, the sqrt(3)/2 scaling, phase sums and clamping.
    logic signed [31:0]  r_ps;
    logic signed [31:0]  r_pc;
    logic signed [31:0]  r_ps2;
    logic signed [47:0]  r_beta;
    logic signed [UW-1:0] r_u  [0:2];
    logic [UC_W-1:0]     r_cl [0:2];
    logic signed [UW-1:0] off;
    logic signed [UW-1:0] ps_w;
    logic signed [UW-1:0] beta_w;
    logic signed [UW-1:0] n_u  [0:2];
    logic [REG_W-1:0]    lim_min;
    logic [UC_W-1:0]     cap;
    logic [UC_W-1:0]     n_cl [0:2];

    always_comb begin
        off       = signed'({{(UW-REG_W-29){1'b0}}, r_supply, 29'b0});
        ps_w      = UW'(r_ps2);
        beta_w    = UW'(r_beta);
        n_u[0]    = off - (ps_w <<< 15);
        n_u[1]    = off + (ps_w <<< 14) + beta_w;
        n_u[2]    = off + (ps_w <<< 14) - beta_w;
    end

    // Capping at the supply as well as the limit keeps the quotient within the period.
    always_comb begin
        lim_min = (r_limit < r_supply) ? r_limit : r_supply;
        cap     = {lim_min, 30'b0};
        for (int p = 0; p < 3; p++) begin
            if (r_u[p][UW-1]) begin
                n_cl[p] = '0;
            end else if (r_u[p][UW-2:0] > (UW-1)'(cap)) begin
                n_cl[p] = cap;
            end else begin
                n_cl[p] = r_u[p][UC_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sn     <= n_sn;
            r_cs     <= n_cs;
            r_uq_rnd <= r_uq[CORDIC_STEPS];
            r_ps     <= r_uq_rnd * r_sn;
            r_pc     <= r_uq_rnd * r_cs;
            r_ps2    <= r_ps;
            r_beta   <= r_pc * SQRT3_HALF_Q15;
            for (int p = 0; p < 3; p++) begin
                r_u[p]  <= n_u[p];
                r_cl[p] <= n_cl[p];
            end
        end
    end

    // Scale by the period in two halves, then drop the 2^30 fraction.
    logic [SPL+PW-1:0]      r_plo [0:2];
    logic [UC_W-SPL+PW-1:0] r_phi [0:2];
    logic [FW-1:0]          full  [0:2];

    always_comb begin
        for (int p = 0; p < 3; p++) begin
            full[p] = (FW'(r_phi[p]) << SPL) + FW'(r_plo[p]);
        end
    end

    // Restoring divider by the supply, one quotient bit per stage.
    logic [NW-1:0] r_rem [0:PW][0:2];
    logic [PW-1:0] r_q   [0:PW][0:2];
    logic [NW-1:0] n_rem [0:PW-1][0:2];
    logic [PW-1:0] n_q   [0:PW-1][0:2];
    logic [NW-1:0] dvs   [0:PW-1];

    always_comb begin
        for (int k = 0; k < PW; k++) begin
            dvs[k] = NW'(r_supply) << (PW - 1 - k);
            for (int p = 0; p < 3; p++) begin
                if (r_rem[k][p] >= dvs[k]) begin
                    n_rem[k][p] = r_rem[k][p] - dvs[k];
                    n_q[k][p]   = r_q[k][p] | (PW'(1) << (PW - 1 - k));
                end else begin
                    n_rem[k][p] = r_rem[k][p];
                    n_q[k][p]   = r_q[k][p];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int p = 0; p < 3; p++) begin
                r_plo[p]    <= r_cl[p][SPL-1:0] * PERIOD;
                r_phi[p]    <= r_cl[p][UC_W-1:SPL] * PERIOD;
                r_rem[0][p] <= full[p][FW-1:30];
                r_q[0][p]   <= '0;
                for (int k = 0; k < PW; k++) begin
                    r_rem[k+1][p] <= n_rem[k][p];
                    r_q[k+1][p]   <= n_q[k][p];
                end
            end
        end
    end

    // Output packing; a zero supply forces zero duties and raises the flag.
    logic              sup_zero;
    logic [DUTY_W-1:0] duty [0:2];

    always_comb begin
        sup_zero = (r_supply == '0);
        for (int p = 0; p < 3; p++) begin
            duty[p] = sup_zero ? '0 : DUTY_W'(r_q[PW][p]);
        end
    end

    assign o_m_tdata = {{(OUT_TDATA_W-3*DUTY_W){1'b0}}, duty[2], duty[1], duty[0]};
    assign o_m_tuser = OUT_TUSER_W'(sup_zero);

endmodule

[rtl/ipcp_checker.sv]
// Port-level checker for the inverse Park/Clarke PWM block, with its bind statement.
module ipcp_checker #(
    parameter int PWM_PERIOD = ipcp_pkg::PWM_PERIOD_DEF
) (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_cfg_we,
    input ipcp_pkg::t_reg_idx               i_cfg_idx,
    input logic [ipcp_pkg::REG_W-1:0]       i_cfg_wdata,
    input logic                             i_s_tvalid,
    input logic                             o_s_tready,
    input logic [ipcp_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    input logic                             o_m_tvalid,
    input logic                             i_m_tready,
    input logic [ipcp_pkg::OUT_TDATA_W-1:0] o_m_tdata,
    input logic [ipcp_pkg::OUT_TUSER_W-1:0] o_m_tuser
);
    import ipcp_pkg::*;

    // A result beat that is not taken stays valid and unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=>
            o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("output beat changed while stalled");

    // The pipeline takes a beat whenever its output register is free or draining.
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_m_tvalid || i_m_tready) |-> o_s_tready)
        else $error("input stalled with a free output register");

    // A zero supply flag comes with all duties at zero.
    a_zero_duty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[0] |-> (o_m_tdata[3*DUTY_W-1:0] == '0))
        else $error("nonzero duty with zero supply");

    // No duty exceeds the PWM period.
    a_duty_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |->
            (32'(o_m_tdata[DUTY_W-1:0]) <= PWM_PERIOD) &&
            (32'(o_m_tdata[2*DUTY_W-1:DUTY_W]) <= PWM_PERIOD) &&
            (32'(o_m_tdata[3*DUTY_W-1:2*DUTY_W]) <= PWM_PERIOD))
        else $error("duty above PWM period");

endmodule

bind inverse_park_clarke_pwm_duty_top ipcp_checker #(.PWM_PERIOD(PWM_PERIOD)) u_ipcp_checker (.*);

[test/inverse_park_clarke_pwm_duty_top_tb.sv]
// Self-checking testbench for the inverse Park/Clarke PWM duty block.
module inverse_park_clarke_pwm_duty_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ipcp_pkg::*;

    localparam int PERIOD      = PWM_PERIOD_DEF;
    localparam int DRAIN_WAIT  = 60;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PRINT_CAP   = 20;

    // Sine/cosine generator constants, full turn equal to 2^32.
    localparam longint GAIN_Q30  = 652032874;
    localparam longint SQRT3_Q15 = 28378;
    localparam longint ATAN_TURN32 [24] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81
    };

    typedef struct packed {
        logic [DUTY_W-1:0] duty_a;
        logic [DUTY_W-1:0] duty_b;
        logic [DUTY_W-1:0] duty_c;
        logic              supply_zero;
    } t_duties;

    // Predicts duties for each accepted beat and checks result beats in order.
    class duty_scoreboard;
        logic [REG_W-1:0] supply_mv;
        logic [REG_W-1:0] limit_mv;
        t_duties          pending[$];
        int               mismatches;
        int               beats_in;
        int               beats_out;
        int               saturated;
        int               clamped_low;
        int               zero_supply;

        function new();
            supply_mv = SUPPLY_RST;
            limit_mv  = LIMIT_RST;
        endfunction

        function void set_reg(t_reg_idx idx, logic [REG_W-1:0] val);
            if (idx == REG_SUPPLY) supply_mv = val;
            else if (idx == REG_LIMIT) limit_mv = val;
        endfunction

        // Round a Q30 value to Q15 with a floor shift and a symmetric clamp.
        function longint to_q15(longint v);
            longint r;
            r = (v + 16384) >>> 15;
            if (r > 32767) r = 32767;
            if (r < -32767) r = -32767;
            return r;
        endfunction

        // First-quadrant CORDIC, then mapped to the quadrant by symmetry.
        function void sin_cos(input logic [ANG_W-1:0] ang, output longint sn,
                              output longint cs);
            longint x, y, z, dx, dy, s, c;
            logic [31:0] phase;
            phase = {ang, 20'd0};
            x = GAIN_Q30;
            y = 0;
            z = phase[29:0];
            for (int i = 0; i < 24; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0) begin
                    x = x - dx; y = y + dy; z = z - ATAN_TURN32[i];
                end else begin
                    x = x + dx; y = y - dy; z = z + ATAN_TURN32[i];
                end
            end
            s = to_q15(y);
            c = to_q15(x);
            case (phase[31:30])
                2'd0: begin sn = s;  cs = c;  end
                2'd1: begin sn = c;  cs = -s; end
                2'd2: begin sn = -s; cs = -c; end
                default: begin sn = -c; cs = s; end
            endcase
        endfunction

        // Clamp one phase voltage, divide by the supply and scale to counts.
        function logic [DUTY_W-1:0] phase_duty(longint u, longint lim);
            longint unsigned num, den, d;
            if (u < 0) u = 0;
            if (u > lim) u = lim;
            num = u;
            num = num * PERIOD;
            den = supply_mv;
            den = den << 30;
            d = num / den;
            if (d > PERIOD) d = PERIOD;
            if (d == PERIOD) saturated++;
            if (d == 0) clamped_low++;
            return d[DUTY_W-1:0];
        endfunction

        function t_duties predict(logic signed [QV_W-1:0] qv, logic [ANG_W-1:0] ang);
            t_duties r;
            longint uq, sn, cs, off, half_a, beta, lim;
            r = '0;
            if (supply_mv == 0) begin
                r.supply_zero = 1'b1;
                zero_supply++;
                return r;
            end
            uq = qv;
            sin_cos(ang, sn, cs);
            off = supply_mv;
            off = off << 29;
            lim = limit_mv;
            lim = lim << 30;
            half_a = uq * sn * 16384;
            beta   = uq * cs * SQRT3_Q15;
            r.duty_a = phase_duty(off - uq * sn * 32768, lim);
            r.duty_b = phase_duty(half_a + beta + off, lim);
            r.duty_c = phase_duty(half_a - beta + off, lim);
            return r;
        endfunction

        function void note_input(logic [IN_TDATA_W-1:0] tdata);
            pending.push_back(predict(tdata[15:0], tdata[27:16]));
            beats_in++;
        endfunction

        task report(string what, longint got, longint want);
            if (mismatches < PRINT_CAP)
                $display("MISMATCH result %0d %s: got %0d expected %0d",
                         beats_out, what, got, want);
            mismatches++;
        endtask

        task check_result(logic [OUT_TDATA_W-1:0] tdata, logic [OUT_TUSER_W-1:0] tuser);
            t_duties want;
            if (pending.size() == 0) begin
                report("beat with nothing pending", 1, 0);
                return;
            end
            want = pending.pop_front();
            if (tdata[12:0] != want.duty_a) report("duty_a", tdata[12:0], want.duty_a);
            if (tdata[25:13] != want.duty_b) report("duty_b", tdata[25:13], want.duty_b);
            if (tdata[38:26] != want.duty_c) report("duty_c", tdata[38:26], want.duty_c);
            if (tuser[0] != want.supply_zero)
                report("supply_zero", tuser[0], want.supply_zero);
            beats_out++;
        endtask
    endclass

    logic                   i_clk;
    logic                   i_rst_n     = 1'b0;
    logic                   i_cfg_we    = 1'b0;
    t_reg_idx               i_cfg_idx   = REG_SUPPLY;
    logic [REG_W-1:0]       i_cfg_wdata = '0;
    logic                   i_s_tvalid  = 1'b0;
    logic                   o_s_tready;
    logic [IN_TDATA_W-1:0]  i_s_tdata   = '0;
    logic                   o_m_tvalid;
    logic                   i_m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_tdata;
    logic [OUT_TUSER_W-1:0] o_m_tuser;

    duty_scoreboard sb = new();
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_left      = 0;
    int cycles         = 0;
    int settings_used  = 1;

    inverse_park_clarke_pwm_duty_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Result side: check each accepted beat, then pick the next ready value.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) sb.check_result(o_m_tdata, o_m_tuser);
        if (hold_left > 0) begin
            hold_left--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results pending",
                     cycles, sb.pending.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Offer one input beat, with random idle cycles ahead of it.
    task automatic send_beat(input logic signed [QV_W-1:0] qv, input logic [ANG_W-1:0] ang);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {4'd0, ang, qv};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        sb.note_input({4'd0, ang, qv});
    endtask

    // Stop sending and wait until every predicted result has come back.
    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    // Write both registers on consecutive edges; only called while idle.
    task automatic set_regs(input logic [REG_W-1:0] supply, input logic [REG_W-1:0] limit);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= REG_SUPPLY;
        i_cfg_wdata <= supply;
        @(posedge i_clk);
        i_cfg_idx   <= REG_LIMIT;
        i_cfg_wdata <= limit;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_reg(REG_SUPPLY, supply);
        sb.set_reg(REG_LIMIT, limit);
        settings_used++;
    endtask

    function automatic logic signed [QV_W-1:0] rand_qv();
        case ($urandom_range(0, 7))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'($urandom_range(0, 200)) - 16'sd100;
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic logic [ANG_W-1:0] rand_angle();
        if ($urandom_range(0, 9) == 0) return {2'($urandom_range(0, 3)), 10'd0};
        return 12'($urandom());
    endfunction

    // One random phase: settings, idle mix, optional long receiver hold-off.
    task automatic run_phase(input logic [REG_W-1:0] supply, input logic [REG_W-1:0] limit,
                             input int send_pct, input int recv_pct, input int hold,
                             input int beats);
        set_regs(supply, limit);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        hold_left      = hold;
        repeat (beats) send_beat(rand_qv(), rand_angle());
        drain_results();
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: field extremes and quadrant edges at the reset settings.
        send_beat(16'sh0000, 12'd0);
        send_beat(16'sh7FFF, 12'd0);
        send_beat(16'sh8000, 12'd0);
        send_beat(16'sh7FFF, 12'd1024);
        send_beat(16'sh8000, 12'd1024);
        send_beat(16'sh7FFF, 12'd2048);
        send_beat(16'sh8000, 12'd3072);
        send_beat(16'sh0001, 12'd4095);
        send_beat(16'shFFFF, 12'd2047);
        send_beat(16'sd12345, 12'd683);
        drain_results();

        // Zero supply forces zero duties and raises the flag.
        set_regs(16'd0, LIMIT_RST);
        send_beat(16'sd1000, 12'd100);
        send_beat(16'sh8000, 12'd4095);
        drain_results();

        // Zero limit clamps every phase to zero.
        set_regs(16'd60000, 16'd0);
        send_beat(16'sh7FFF, 12'd512);
        send_beat(-16'sd5000, 12'd3000);
        drain_results();

        // Small supply with a wide limit: phases above the supply saturate.
        set_regs(16'd1000, 16'd60000);
        send_beat(16'sh7FFF, 12'd0);
        send_beat(16'sh8000, 12'd1500);
        send_beat(16'sd20000, 12'd3500);
        drain_results();

        set_regs(16'd60000, 16'd60000);
        send_beat(16'sh7FFF, 12'd1365);
        send_beat(16'sh8000, 12'd2730);
        drain_results();

        // Random phases over several settings and idle mixes.
        run_phase(SUPPLY_RST, LIMIT_RST, 0, 0, 0, 100);
        run_phase(16'($urandom_range(1, 60000)), 16'($urandom_range(0, 60000)), 61, 0, 0, 100);
        run_phase(16'($urandom_range(1, 60000)), 16'($urandom_range(0, 60000)), 0, 61, 0, 100);
        run_phase(16'($urandom_range(1, 60000)), 16'($urandom_range(0, 60000)), 31, 31, 0, 100);
        // Receiver holds off long enough for the pipeline to fill and stall input.
        run_phase(SUPPLY_RST, 16'd60000, 0, 0, 300, 150);
        run_phase(16'd60000, 16'd60000, 31, 31, 0, 80);
        run_phase(16'hFFFF, 16'hFFFF, 61, 61, 0, 60);
        run_phase(16'($urandom_range(1, 300)), 16'($urandom_range(0, 60000)), 31, 31, 0, 80);
        run_phase(16'd0, 16'($urandom_range(0, 65535)), 0, 0, 0, 30);

        $display("Sent %0d beats over %0d register settings, checked %0d results.",
                 sb.beats_in, settings_used, sb.beats_out);
        $display("Predicted %0d saturated and %0d zero phase duties, %0d zero-supply beats.",
                 sb.saturated, sb.clamped_low, sb.zero_supply);
        if (sb.mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/ipcp_pkg.sv
rtl/inverse_park_clarke_pwm_duty_top.sv
rtl/ipcp_checker.sv
test/inverse_park_clarke_pwm_duty_top_tb.sv
